>>> design/dbic_pkg.sv
// ----------------------------------------------------------------------------
// dbic_pkg
// Shared types and constants for the delta block index combiner.
// ----------------------------------------------------------------------------
package dbic_pkg;

  localparam int POS_W = 48;  // byte positions and sizes
  localparam int ENT_W = 49;  // signed index entries

  // Configuration register indexes
  localparam logic CFG_FIRST_START  = 1'b0;
  localparam logic CFG_SECOND_START = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_XLATE = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SCAN,
    ST_SIZE,
    ST_DONE
  } state_t;

  // One table word: present block keeps its data position, a reference keeps
  // its encoded value.
  typedef struct packed {
    logic             present;
    logic [ENT_W-1:0] value;
  } tbl_entry_t;

endpackage

>>> design/dbic_table.sv
// ----------------------------------------------------------------------------
// dbic_table
// Block index table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dbic_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  dbic_pkg::tbl_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output dbic_pkg::tbl_entry_t rd_data
);
  import dbic_pkg::*;

  tbl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/delta_block_index_combiner_unit.sv
// ----------------------------------------------------------------------------
// delta_block_index_combiner_unit
// Merges the block indexes of two chained deltas. Load, translate, clear
// and no-op commands each return one result on the done strobe.
// After accept: load, clear, no-op, second-delta translate and out-of-range
//   reference go from execute to done; an absent-block reference adds a table
//   fetch; a present-block one adds it, a scan of any later entries for
//   the next present block at one table read per cycle, and a size step.
// The receiver cannot stall; done is high for exactly one cycle.
// Reset idles the sequencer, zeroes the loaded count, and returns the data
// start registers and running positions to their defaults (first 1, second
// 0). The table itself is never cleared.
// ----------------------------------------------------------------------------
module delta_block_index_combiner_unit #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func,
  input  logic signed [dbic_pkg::ENT_W-1:0]  encoded_size,
  // result channel
  output logic                               done,
  output logic signed [dbic_pkg::ENT_W-1:0]  out_entry,
  output logic                               copy_valid,
  output logic                               copy_from_first,
  output logic [dbic_pkg::POS_W-1:0]         copy_position,
  output logic [dbic_pkg::POS_W-1:0]         copy_size,
  output logic                               error,
  // configuration
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [dbic_pkg::POS_W-1:0]         cfg_data
);
  import dbic_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  state_t state, state_next;

  // latched command
  func_t            func_q;
  logic [ENT_W-1:0] enc;

  // job state
  logic [CW-1:0]    loaded_count;
  logic [POS_W-1:0] first_data_start;
  logic [POS_W-1:0] second_data_start;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] second_pos;

  // scan state
  logic [CW-1:0]    nb;
  logic [POS_W-1:0] from_pos;
  logic [POS_W-1:0] end_pos;

  // result registers
  logic [ENT_W-1:0] res_entry;
  logic             res_cvalid;
  logic             res_cfirst;
  logic [POS_W-1:0] res_cpos;
  logic [POS_W-1:0] res_csize;
  logic             res_err;

  // table port
  logic       wr_en;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  tbl_entry_t wr_data;
  tbl_entry_t ent;

  // shared 48-bit add/subtract unit
  logic [POS_W-1:0] add_a;
  logic [POS_W-1:0] add_b;
  logic             add_sub;
  logic [POS_W-1:0] sum;

  // decode
  logic             positive;
  logic [ENT_W-1:0] idx;
  logic             in_range;
  logic             full;
  logic             scan_more;

  assign positive  = (enc != '0) && !enc[ENT_W-1];
  assign idx       = '0 - enc;
  assign in_range  = idx < {{(ENT_W-CW){1'b0}}, loaded_count};
  assign full      = loaded_count == CW'(MAX_BLOCKS);
  assign scan_more = nb < loaded_count;

  assign sum = add_a + (add_sub ? ~add_b : add_b) + {{(POS_W-1){1'b0}}, add_sub};

  dbic_table #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded_count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC: begin
        if (func_q == FUNC_XLATE && !positive && in_range) state_next = ST_FETCH;
        else state_next = ST_DONE;
      end
      ST_FETCH: begin
        if (!ent.present) state_next = ST_DONE;
        else if (scan_more) state_next = ST_SCAN;
        else state_next = ST_SIZE;
      end
      ST_SCAN: begin
        if (ent.present || !scan_more) state_next = ST_SIZE;
      end
      ST_SIZE:  state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: table port, adder operands, handshake
  always_comb begin
    busy    = 1'b1;
    done    = 1'b0;
    wr_en   = 1'b0;
    wr_data = '{present: 1'b0, value: enc};
    rd_en   = 1'b0;
    rd_addr = nb[AW-1:0];
    add_a   = first_pos;
    add_b   = enc[POS_W-1:0];
    add_sub = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        if (func_q == FUNC_LOAD && !full) begin
          wr_en = 1'b1;
          if (positive) wr_data = '{present: 1'b1, value: {1'b0, first_pos}};
        end
        if (func_q == FUNC_XLATE) add_a = second_pos;
        rd_addr = idx[AW-1:0];
        rd_en   = func_q == FUNC_XLATE && !positive && in_range;
      end
      ST_FETCH: rd_en = ent.present && scan_more;
      ST_SCAN:  rd_en = !ent.present && scan_more;
      ST_SIZE: begin
        add_a   = end_pos;
        add_b   = from_pos;
        add_sub = 1'b1;
      end
      ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // job state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count      <= '0;
      first_data_start  <= POS_W'(1);
      second_data_start <= '0;
      first_pos         <= POS_W'(1);
      second_pos        <= '0;
    end else begin
      if (state == ST_EXEC) begin
        unique case (func_q)
          FUNC_LOAD: begin
            if (!full) begin
              loaded_count <= loaded_count + CW'(1);
              if (positive) first_pos <= sum;
            end
          end
          FUNC_XLATE: if (positive) second_pos <= sum;
          FUNC_CLEAR: begin
            loaded_count <= '0;
            first_pos    <= first_data_start;
            second_pos   <= second_data_start;
          end
          FUNC_NOP: ;
          default: ;
        endcase
      end
      // Written only while idle, so no conflict with the updates above: a user's rule the block leaves unenforced.
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FIRST_START: begin
            first_data_start <= cfg_data;
            first_pos        <= cfg_data;
          end
          CFG_SECOND_START: begin
            second_data_start <= cfg_data;
            second_pos        <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  // command latch, scan registers and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          func_q     <= func_t'(func);
          enc        <= encoded_size;
          res_entry  <= '0;
          res_cvalid <= 1'b0;
          res_cfirst <= 1'b0;
          res_cpos   <= '0;
          res_csize  <= '0;
          res_err    <= 1'b0;
        end
      end
      ST_EXEC: begin
        nb <= idx[CW-1:0] + CW'(1);
        if (func_q == FUNC_LOAD) begin
          res_err <= full;
        end else if (func_q == FUNC_XLATE) begin
          if (positive) begin
            res_entry  <= enc;
            res_cvalid <= 1'b1;
            res_cpos   <= second_pos;
            res_csize  <= enc[POS_W-1:0];
          end else begin
            res_err <= !in_range;
          end
        end
      end
      ST_FETCH: begin
        from_pos <= ent.value[POS_W-1:0];
        end_pos  <= first_pos;
        if (!ent.present) res_entry <= ent.value;
        if (rd_en) nb <= nb + CW'(1);
      end
      ST_SCAN: begin
        if (ent.present) end_pos <= ent.value[POS_W-1:0];
        if (rd_en) nb <= nb + CW'(1);
      end
      ST_SIZE: begin
        res_entry  <= {1'b0, sum};
        res_csize  <= sum;
        res_cpos   <= from_pos;
        res_cvalid <= 1'b1;
        res_cfirst <= 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign out_entry       = res_entry;
  assign copy_valid      = res_cvalid;
  assign copy_from_first = res_cfirst;
  assign copy_position   = res_cpos;
  assign copy_size       = res_csize;
  assign error           = res_err;

endmodule

>>> design/dbic_checker.sv
// ----------------------------------------------------------------------------
// dbic_checker
// Port-level checks for the delta block index combiner, bound to the top.
// ----------------------------------------------------------------------------
module dbic_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              copy_valid,
  input logic signed [dbic_pkg::ENT_W-1:0] out_entry,
  input logic [dbic_pkg::POS_W-1:0]        copy_size,
  input logic                              error
);
  import dbic_pkg::*;

  // an accepted command makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  // a result comes only while a command is in flight, and ends it
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 (!busy && !done))
    else $error("result transfer outside a command");

  // busy drops only right after a result
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  // a copy always carries its size as the entry; errors never copy
  a_copy_entry: assert property (@(posedge clk) disable iff (rst)
    done && copy_valid |-> !error && out_entry == {1'b0, copy_size})
    else $error("copy result inconsistent");

endmodule

bind delta_block_index_combiner_unit dbic_checker u_dbic_checker (.*);

>>> sim/combiner_check_pkg.sv
// ----------------------------------------------------------------------------
// combiner_check_pkg
// Scoreboard for the delta block index combiner: predicts each command's
// rewritten entry and copy descriptor and compares them with the block.
// ----------------------------------------------------------------------------
package combiner_check_pkg;
  import dbic_pkg::*;

  localparam int TABLE_DEPTH = 4096;

  typedef struct packed {
    logic [ENT_W-1:0] entry;
    logic             copy_valid;
    logic             from_first;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] length;
    logic             err_flag;
  } index_result_t;

  class combiner_scoreboard;
    logic [POS_W-1:0] first_start;
    logic [POS_W-1:0] second_start;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] second_pos;
    logic [ENT_W-1:0] stored [TABLE_DEPTH];
    bit               is_block [TABLE_DEPTH];
    int               loaded;
    index_result_t    awaited [$];
    int mismatches, checked;
    int n_loads, n_full, n_clears, n_nops;
    int n_second, n_first, n_kept, n_bad_ref;

    function new();
      first_start  = 1;
      second_start = 0;
      restart_job();
    endfunction

    function void restart_job();
      loaded     = 0;
      first_pos  = first_start;
      second_pos = second_start;
    endfunction

    // register write also reloads the matching running position
    function void load_register(logic idx, logic [POS_W-1:0] value);
      if (idx == CFG_FIRST_START) begin
        first_start = value;
        first_pos   = value;
      end else begin
        second_start = value;
        second_pos   = value;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void note_command(func_t op, logic [ENT_W-1:0] enc);
      index_result_t    r;
      logic [ENT_W-1:0] ref_idx;
      logic [POS_W-1:0] stop;
      bit               positive;
      bit               found;
      int               ix;
      int               nb;
      r = '0;
      positive = (enc != '0) && !enc[ENT_W-1];
      case (op)
        FUNC_LOAD: begin
          n_loads++;
          if (loaded >= TABLE_DEPTH) begin
            r.err_flag = 1'b1;
            n_full++;
          end else begin
            is_block[loaded] = positive;
            if (positive) begin
              stored[loaded] = {1'b0, first_pos};
              first_pos      = first_pos + enc[POS_W-1:0];
            end else begin
              stored[loaded] = enc;
            end
            loaded++;
          end
        end
        FUNC_XLATE: begin
          if (positive) begin
            r.entry      = enc;
            r.copy_valid = 1'b1;
            r.position   = second_pos;
            r.length     = enc[POS_W-1:0];
            second_pos   = second_pos + enc[POS_W-1:0];
            n_second++;
          end else begin
            ref_idx = -enc;
            if (ref_idx >= loaded) begin
              r.err_flag = 1'b1;
              n_bad_ref++;
            end else begin
              ix = int'(ref_idx);
              if (is_block[ix]) begin
                // block runs up to the next present block, else to the end
                stop  = first_pos;
                found = 1'b0;
                for (nb = ix + 1; nb < loaded && !found; nb++) begin
                  if (is_block[nb]) begin
                    stop  = stored[nb][POS_W-1:0];
                    found = 1'b1;
                  end
                end
                r.length     = stop - stored[ix][POS_W-1:0];
                r.entry      = {1'b0, r.length};
                r.copy_valid = 1'b1;
                r.from_first = 1'b1;
                r.position   = stored[ix][POS_W-1:0];
                n_first++;
              end else begin
                r.entry = stored[ix];
                n_kept++;
              end
            end
          end
        end
        FUNC_CLEAR: begin
          restart_job();
          n_clears++;
        end
        default: n_nops++;
      endcase
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_entry(index_result_t got);
      index_result_t want;
      if (awaited.size() == 0) begin
        $error("result strobe with no command outstanding");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("out_entry", 64'(want.entry), 64'(got.entry));
      compare_field("copy_valid", 64'(want.copy_valid), 64'(got.copy_valid));
      compare_field("copy_from_first", 64'(want.from_first), 64'(got.from_first));
      compare_field("copy_position", 64'(want.position), 64'(got.position));
      compare_field("copy_size", 64'(want.length), 64'(got.length));
      compare_field("error", 64'(want.err_flag), 64'(got.err_flag));
    endfunction
  endclass

endpackage

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for delta_block_index_combiner_unit. A directed run
// hits the field extremes and the corner cases of table lookup, a second run
// fills the table to overflow, then random jobs (clear, loads, translates)
// run under three sender idle profiles. Every result is predicted and checked.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbic_pkg::*;
  import combiner_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 16;  // longer than any non-scan latency
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              func = FUNC_NOP;
  logic signed [ENT_W-1:0] encoded_size = '0;
  logic                    done;
  logic signed [ENT_W-1:0] out_entry;
  logic                    copy_valid;
  logic                    copy_from_first;
  logic [POS_W-1:0]        copy_position;
  logic [POS_W-1:0]        copy_size;
  logic                    error;
  logic                    cfg_write = 1'b0;
  logic                    cfg_index = CFG_FIRST_START;
  logic [POS_W-1:0]        cfg_data = '0;

  combiner_scoreboard sb;
  index_result_t      seen;
  int                 sender_idle_pct = 0;
  int                 items_sent = 0;     // no-ops excluded
  int unsigned        cycles = 0;

  delta_block_index_combiner_unit #(
    .MAX_BLOCKS(TABLE_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .encoded_size    (encoded_size),
    .done            (done),
    .out_entry       (out_entry),
    .copy_valid      (copy_valid),
    .copy_from_first (copy_from_first),
    .copy_position   (copy_position),
    .copy_size       (copy_size),
    .error           (error),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a hung handshake or a lost strobe ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("no completion after %0d cycles", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. done marks a one-cycle transfer; values are sampled at the
  // edge that closes that cycle, so they are the pre-edge register outputs.
  always @(posedge clk) begin
    if (!rst && done) begin
      seen.entry      = out_entry;
      seen.copy_valid = copy_valid;
      seen.from_first = copy_from_first;
      seen.position   = copy_position;
      seen.length     = copy_size;
      seen.err_flag   = error;
      sb.check_entry(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Value generators
  // --------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[POS_W-1:0];
  endfunction

  function automatic logic [ENT_W-1:0] rand_entry();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ENT_W-1:0];
  endfunction

  // negated block number / original-file reference
  function automatic logic [ENT_W-1:0] neg_word(logic [POS_W-1:0] mag);
    return -{1'b0, mag};
  endfunction

  // positive stored size: mostly small, some full-range for wrap and bit toggling
  function automatic logic [ENT_W-1:0] size_word();
    logic [POS_W-1:0] v;
    case ($urandom_range(9))
      0:       v = POS_MAX;
      1, 2:    v = rand_pos();
      3:       v = 1;
      default: v = POS_W'($urandom_range(1, 5000));
    endcase
    if (v == '0) v = 1;
    return {1'b0, v};
  endfunction

  function automatic logic [ENT_W-1:0] load_word();
    if ($urandom_range(99) < 55) return size_word();
    if ($urandom_range(7) == 0) return '0;
    if ($urandom_range(1) == 0) return neg_word(POS_W'($urandom_range(1, 999)));
    return neg_word(rand_pos());
  endfunction

  // translate entries: mostly sizes and in-range references, some misses
  function automatic logic [ENT_W-1:0] xlate_word();
    int k;
    k = $urandom_range(99);
    if (k < 40) return size_word();
    if (k < 88 && sb.loaded > 0)
      return neg_word(POS_W'($urandom_range(sb.loaded - 1)));
    if (k < 96) return neg_word(POS_W'(sb.loaded + $urandom_range(3)));
    return neg_word(rand_pos());
  endfunction

  function automatic logic [POS_W-1:0] rand_first_start();
    logic [POS_W-1:0] v;
    v = rand_pos();
    return (v == '0) ? POS_W'(1) : v;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One idle cycle on the command side; fields carry junk while start is low.
  task automatic idle_one();
    start        <= 1'b0;
    func         <= 2'($urandom_range(3));
    encoded_size <= rand_entry();
    @(posedge clk);
  endtask

  // Present one command and hold it until the transfer (start && !busy at
  // an edge). start is left high so back-to-back commands need no toggle.
  task automatic send_item(func_t op, logic [ENT_W-1:0] enc);
    while ($urandom_range(99) < sender_idle_pct) idle_one();
    start        <= 1'b1;
    func         <= op;
    encoded_size <= enc;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, enc);
    if (op != FUNC_NOP) items_sent++;
  endtask

  // Stop issuing and wait for every outstanding result and for the block to
  // drop busy. Every command returns a result, so nothing else is pending.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0 || busy) @(posedge clk);
  endtask

  // Only called with the block drained.
  task automatic write_reg(logic idx, logic [POS_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.load_register(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Occasional full drain (back-pressure from the sender side), sometimes
  // followed by a register write that reloads a running position mid-job.
  task automatic maybe_pause();
    if ($urandom_range(39) == 0) begin
      wait_until_drained();
      if ($urandom_range(1) == 0) begin
        if ($urandom_range(1) == 0) write_reg(CFG_FIRST_START, rand_first_start());
        else write_reg(CFG_SECOND_START, rand_pos());
      end
    end
  endtask

  // Well-formed job: clear, load the first index, translate the second.
  // A few loads and arbitrary commands are mixed into the translate stream,
  // and a missing clear lets the table carry over from the previous job.
  task automatic run_job();
    int n_loads;
    int n_refs;
    int k;
    if ($urandom_range(9) != 0) send_item(FUNC_CLEAR, rand_entry());
    n_loads = ($urandom_range(7) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 16);
    repeat (n_loads) begin
      maybe_pause();
      send_item(FUNC_LOAD, load_word());
    end
    n_refs = $urandom_range(1, 24);
    repeat (n_refs) begin
      maybe_pause();
      k = $urandom_range(99);
      if (k < 6) send_item(FUNC_LOAD, load_word());
      else if (k < 9) send_item(func_t'($urandom_range(3)), rand_entry());
      else send_item(FUNC_XLATE, xlate_word());
    end
  endtask

  task automatic run_phase(int idle_pct, int n_items, logic [POS_W-1:0] first,
                           logic [POS_W-1:0] second);
    int target;
    wait_until_drained();
    write_reg(CFG_FIRST_START, first);
    write_reg(CFG_SECOND_START, second);
    sender_idle_pct = idle_pct;
    target = items_sent + n_items;
    while (items_sent < target) run_job();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first data starts at 1, second at the top of the range so
    // both running positions wrap early.
    write_reg(CFG_FIRST_START, POS_W'(1));
    write_reg(CFG_SECOND_START, POS_MAX);
    send_item(FUNC_XLATE, '0);                        // empty table: out of range
    send_item(FUNC_NOP, rand_entry());
    send_item(FUNC_LOAD, {1'b0, POS_MAX});            // largest block, position wraps
    send_item(FUNC_LOAD, '0);                         // reference zero
    send_item(FUNC_LOAD, neg_word(POS_MAX));          // reference of largest 48-bit magnitude
    send_item(FUNC_LOAD, ENT_W'(1));                  // smallest block
    send_item(FUNC_LOAD, neg_word(POS_W'(5)));
    send_item(FUNC_XLATE, neg_word(POS_W'(0)));       // present, size wraps
    send_item(FUNC_XLATE, neg_word(POS_W'(1)));       // absent, zero reference
    send_item(FUNC_XLATE, neg_word(POS_W'(2)));       // absent, extreme reference
    send_item(FUNC_XLATE, neg_word(POS_W'(3)));       // present, no later block
    send_item(FUNC_XLATE, neg_word(POS_W'(4)));
    send_item(FUNC_XLATE, neg_word(POS_W'(5)));       // index equal to count
    send_item(FUNC_XLATE, {1'b0, POS_MAX});           // largest second-delta copy
    send_item(FUNC_XLATE, ENT_W'(1));
    send_item(FUNC_XLATE, neg_word(POS_MAX));         // far out of range
    send_item(FUNC_CLEAR, rand_entry());
    send_item(FUNC_XLATE, '0);                        // after clear: out of range
    send_item(FUNC_LOAD, ENT_W'(1));
    send_item(FUNC_NOP, rand_entry());
    wait_until_drained();

    // Fill the table: blocks at both ends, references between, so the first
    // lookup scans the whole table. Then overflow it.
    write_reg(CFG_FIRST_START, rand_first_start());
    write_reg(CFG_SECOND_START, rand_pos());
    send_item(FUNC_CLEAR, '0);
    send_item(FUNC_LOAD, size_word());
    repeat (TABLE_DEPTH - 2) send_item(FUNC_LOAD, neg_word(POS_W'($urandom_range(0, 999))));
    send_item(FUNC_LOAD, size_word());
    send_item(FUNC_LOAD, size_word());                // table full
    send_item(FUNC_LOAD, neg_word(POS_W'(7)));        // table full
    send_item(FUNC_XLATE, neg_word(POS_W'(0)));       // longest scan
    send_item(FUNC_XLATE, neg_word(POS_W'(TABLE_DEPTH - 1)));
    send_item(FUNC_XLATE, neg_word(POS_W'(TABLE_DEPTH - 2)));
    send_item(FUNC_XLATE, neg_word(POS_W'(TABLE_DEPTH)));
    send_item(FUNC_CLEAR, '0);

    // Random jobs: light sender idling, heavy idling, then none.
    run_phase(9, 434, POS_MAX, '0);
    run_phase(76, 433, rand_first_start(), rand_pos());
    run_phase(0, 433, POS_W'(1), POS_MAX);

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
    end
    $display("Checked %0d results: %0d loads (%0d into a full table), %0d clears, %0d no-ops.",
             sb.checked, sb.n_loads, sb.n_full, sb.n_clears, sb.n_nops);
    $display("Translates: %0d second-delta copies, %0d first-delta copies, %0d kept, %0d bad.",
             sb.n_second, sb.n_first, sb.n_kept, sb.n_bad_ref);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
